>>> rtl/wisg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wisg_pkg: shared types and constants
// Field widths, the seed table and the job record for the inverse generator.
// ----------------------------------------------------------------------------
package wisg_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int COUNT_W   = 7;
    localparam int INDEX_W   = 6;
    localparam int MAX_LIMBS = 64;
    localparam int MIN_LIMBS = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] SEED_TAB [128] = '{
        8'd1,   8'd171, 8'd205, 8'd183, 8'd57,  8'd163, 8'd197, 8'd239,
        8'd241, 8'd27,  8'd61,  8'd167, 8'd41,  8'd19,  8'd53,  8'd223,
        8'd225, 8'd139, 8'd173, 8'd151, 8'd25,  8'd131, 8'd165, 8'd207,
        8'd209, 8'd251, 8'd29,  8'd135, 8'd9,   8'd243, 8'd21,  8'd191,
        8'd193, 8'd107, 8'd141, 8'd119, 8'd249, 8'd99,  8'd133, 8'd175,
        8'd177, 8'd219, 8'd253, 8'd103, 8'd233, 8'd211, 8'd245, 8'd159,
        8'd161, 8'd75,  8'd109, 8'd87,  8'd217, 8'd67,  8'd101, 8'd143,
        8'd145, 8'd187, 8'd221, 8'd71,  8'd201, 8'd179, 8'd213, 8'd127,
        8'd129, 8'd43,  8'd77,  8'd55,  8'd185, 8'd35,  8'd69,  8'd111,
        8'd113, 8'd155, 8'd189, 8'd39,  8'd169, 8'd147, 8'd181, 8'd95,
        8'd97,  8'd11,  8'd45,  8'd23,  8'd153, 8'd3,   8'd37,  8'd79,
        8'd81,  8'd123, 8'd157, 8'd7,   8'd137, 8'd115, 8'd149, 8'd63,
        8'd65,  8'd235, 8'd13,  8'd247, 8'd121, 8'd227, 8'd5,   8'd47,
        8'd49,  8'd91,  8'd125, 8'd231, 8'd105, 8'd83,  8'd117, 8'd31,
        8'd33,  8'd203, 8'd237, 8'd215, 8'd89,  8'd195, 8'd229, 8'd15,
        8'd17,  8'd59,  8'd93,  8'd199, 8'd73,  8'd51,  8'd85,  8'd255
    };

    // One classified request waiting for the back end.
    typedef struct packed {
        logic [WORD_W-1:0]  operand;
        logic [COUNT_W-1:0] count;
        logic               bad;
    } t_job;

    // Queue handshake from front to back.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_queue_out;

endpackage

>>> rtl/wisg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wisg_if: request and result channels
// Valid/ready channels carrying the operand request and one inverse limb.
// ----------------------------------------------------------------------------
interface wisg_in_if;
    logic                          valid;
    logic                          ready;
    logic [wisg_pkg::WORD_W-1:0]   operand;
    logic [wisg_pkg::COUNT_W-1:0]  limb_count;

    modport source (output valid, output operand, output limb_count, input ready);
    modport sink   (input valid, input operand, input limb_count, output ready);
endinterface

interface wisg_out_if;
    logic                          valid;
    logic                          ready;
    logic [wisg_pkg::WORD_W-1:0]   limb;
    logic [wisg_pkg::INDEX_W-1:0]  limb_index;
    logic                          last;
    logic                          bad_operand;

    modport source (output valid, output limb, output limb_index, output last,
                    output bad_operand, input ready);
    modport sink   (input valid, input limb, input limb_index, input last,
                    input bad_operand, output ready);
endinterface

>>> rtl/wisg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wisg_front: request intake
// Accepts requests, flags even operands, clamps the limb count and queues them.
// ----------------------------------------------------------------------------
module wisg_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    wisg_in_if.sink                i_in,
    input  logic                   i_pop,
    output wisg_pkg::t_queue_out   o_queue
);

    wisg_pkg::t_job r_slot [wisg_pkg::QUEUE_DEPTH];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_fill;
    logic       w_push, w_pop;
    wisg_pkg::t_job w_job;

    always_comb begin
        w_job.operand = i_in.operand;
        w_job.bad     = ~i_in.operand[0];
        if (i_in.limb_count < wisg_pkg::COUNT_W'(wisg_pkg::MIN_LIMBS)) begin
            w_job.count = wisg_pkg::COUNT_W'(wisg_pkg::MIN_LIMBS);
        end else if (i_in.limb_count > wisg_pkg::COUNT_W'(wisg_pkg::MAX_LIMBS)) begin
            w_job.count = wisg_pkg::COUNT_W'(wisg_pkg::MAX_LIMBS);
        end else begin
            w_job.count = i_in.limb_count;
        end
    end

    assign i_in.ready    = (r_fill != 2'(wisg_pkg::QUEUE_DEPTH));
    assign w_push        = i_in.valid && i_in.ready;
    assign w_pop         = i_pop && (r_fill != 2'd0);
    assign o_queue.valid = (r_fill != 2'd0);
    assign o_queue.job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= r_fill + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_job;
        end
    end

endmodule

>>> rtl/wisg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wisg_mul: multi-cycle 64x64 multiplier
// Forms the full 128-bit product from four 32x32 partial products.
// ----------------------------------------------------------------------------
module wisg_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wisg_pkg::WORD_W-1:0]   i_a,
    input  logic [wisg_pkg::WORD_W-1:0]   i_b,
    output logic                          o_done,
    output logic [2*wisg_pkg::WORD_W-1:0] o_product
);

    logic [wisg_pkg::WORD_W-1:0]   r_a, r_b;
    logic [2*wisg_pkg::WORD_W-1:0] r_acc;
    logic [1:0]                    r_k;
    logic                          r_busy, r_done;
    logic [wisg_pkg::HALF_W-1:0]   w_ha, w_hb;
    logic [wisg_pkg::WORD_W-1:0]   w_pp;
    logic [2*wisg_pkg::WORD_W-1:0] w_addend;

    assign w_ha = r_k[0] ? r_a[wisg_pkg::WORD_W-1:wisg_pkg::HALF_W]
                         : r_a[wisg_pkg::HALF_W-1:0];
    assign w_hb = r_k[1] ? r_b[wisg_pkg::WORD_W-1:wisg_pkg::HALF_W]
                         : r_b[wisg_pkg::HALF_W-1:0];
    assign w_pp = w_ha * w_hb;

    always_comb begin
        case (r_k)
            2'd0:    w_addend = {64'd0, w_pp};
            2'd3:    w_addend = {w_pp, 64'd0};
            default: w_addend = {32'd0, w_pp, 32'd0};
        endcase
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else if (r_busy) begin
            r_k <= r_k + 2'd1;
            if (r_k == 2'd3) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_addend;
        end
    end

endmodule

>>> rtl/wisg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wisg_back: inverse sequencer
// Runs the Newton refinement and the limb recurrence on the shared multiplier.
// ----------------------------------------------------------------------------
module wisg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wisg_pkg::t_queue_out i_queue,
    output logic                 o_pop,
    wisg_out_if.source           o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [3:0] ST_Y0   = 4'd0;
    localparam logic [3:0] ST_R1   = 4'd1;
    localparam logic [3:0] ST_Y1   = 4'd2;
    localparam logic [3:0] ST_R2   = 4'd3;
    localparam logic [3:0] ST_Y2   = 4'd4;
    localparam logic [3:0] ST_R3   = 4'd5;
    localparam logic [3:0] ST_HIGH = 4'd6;
    localparam logic [3:0] ST_LIMB = 4'd7;
    localparam logic [3:0] ST_CARRY = 4'd8;

    localparam int W = wisg_pkg::WORD_W;

    logic [1:0]  r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic [W-1:0] r_a, n_a, r_r, n_r, r_y, n_y, r_h, n_h, r_ninv, n_ninv;
    logic [W-1:0] r_limb, n_limb;
    logic [wisg_pkg::COUNT_W-1:0] r_n, n_n, r_i, n_i;
    logic        r_bad, n_bad;

    logic        r_ovalid;
    logic [W-1:0] r_olimb;
    logic [wisg_pkg::INDEX_W-1:0] r_oindex;
    logic        r_olast, r_obad;

    logic        w_start, w_done, w_load, w_last;
    logic [W-1:0] w_ma, w_mb, w_lo, w_hi, w_sum;
    logic [2*W-1:0] w_prod;

    wisg_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_a       (w_ma),
        .i_b       (w_mb),
        .o_done    (w_done),
        .o_product (w_prod)
    );

    assign w_lo   = w_prod[W-1:0];
    assign w_hi   = w_prod[2*W-1:W];
    assign w_sum  = r_h + w_lo;
    assign w_load = (r_state == S_EMIT) && (!r_ovalid || o_out.ready);
    assign w_last = r_bad || (r_i == r_n - wisg_pkg::COUNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_a     = r_a;
        n_r     = r_r;
        n_y     = r_y;
        n_h     = r_h;
        n_ninv  = r_ninv;
        n_limb  = r_limb;
        n_n     = r_n;
        n_i     = r_i;
        n_bad   = r_bad;
        w_start = 1'b0;
        w_ma    = r_r;
        w_mb    = r_a;
        o_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_queue.valid) begin
                    o_pop = 1'b1;
                    n_a   = i_queue.job.operand;
                    n_n   = i_queue.job.count;
                    n_bad = i_queue.job.bad;
                    n_i   = '0;
                    if (i_queue.job.bad) begin
                        n_limb  = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_r     = W'(wisg_pkg::SEED_TAB[i_queue.job.operand[7:1]]);
                        w_start = 1'b1;
                        w_ma    = n_a;
                        w_mb    = n_r;
                        n_step  = ST_Y0;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (w_done) begin
                    w_start = 1'b1;
                    unique case (r_step)
                        ST_Y0: begin
                            n_y = W'(1) - w_lo;
                            w_ma = r_r; w_mb = W'(2) - w_lo; n_step = ST_R1;
                        end
                        ST_R1: begin
                            n_r = w_lo;
                            w_ma = r_y; w_mb = r_y; n_step = ST_Y1;
                        end
                        ST_Y1: begin
                            n_y = w_lo;
                            w_ma = r_r; w_mb = w_lo + W'(1); n_step = ST_R2;
                        end
                        ST_R2: begin
                            n_r = w_lo;
                            w_ma = r_y; w_mb = r_y; n_step = ST_Y2;
                        end
                        ST_Y2: begin
                            n_y = w_lo;
                            w_ma = r_r; w_mb = w_lo + W'(1); n_step = ST_R3;
                        end
                        ST_R3: begin
                            n_r = w_lo;
                            w_ma = w_lo; w_mb = r_a; n_step = ST_HIGH;
                        end
                        ST_HIGH: begin
                            w_start = 1'b0;
                            n_h     = w_hi;
                            n_ninv  = W'(0) - r_r;
                            n_limb  = r_r;
                            n_state = S_EMIT;
                        end
                        ST_LIMB: begin
                            w_start = 1'b0;
                            n_limb  = w_lo;
                            n_state = S_EMIT;
                        end
                        ST_CARRY: begin
                            n_h    = w_hi + W'(w_sum < w_lo);
                            n_i    = r_i + wisg_pkg::COUNT_W'(1);
                            w_ma   = r_ninv;
                            w_mb   = n_h;
                            n_step = ST_LIMB;
                        end
                        default: begin
                            w_start = 1'b0;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else if (r_step == ST_HIGH) begin
                        n_i     = r_i + wisg_pkg::COUNT_W'(1);
                        w_start = 1'b1;
                        w_ma    = r_ninv;
                        w_mb    = r_h;
                        n_step  = ST_LIMB;
                        n_state = S_MUL;
                    end else begin
                        w_start = 1'b1;
                        w_ma    = r_limb;
                        w_mb    = r_a;
                        n_step  = ST_CARRY;
                        n_state = S_MUL;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_Y0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_r    <= n_r;
        r_y    <= n_y;
        r_h    <= n_h;
        r_ninv <= n_ninv;
        r_limb <= n_limb;
        r_n    <= n_n;
        r_i    <= n_i;
        r_bad  <= n_bad;
        if (w_load) begin
            r_olimb  <= r_limb;
            r_oindex <= r_i[wisg_pkg::INDEX_W-1:0];
            r_olast  <= w_last;
            r_obad   <= r_bad;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.limb        = r_olimb;
    assign o_out.limb_index  = r_oindex;
    assign o_out.last        = r_olast;
    assign o_out.bad_operand = r_obad;

endmodule

>>> rtl/word_inverse_series_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_inverse_series_gen: limb-serial inverse modulo 2^(64n)
// Top level: request queue, sequencer and result register.
// ----------------------------------------------------------------------------
// Each request carries an odd 64-bit operand and a limb count n (clamped to
// 2..64); the block returns the n limbs of operand^-1 mod 2^(64n), least
// significant first, with last set on the final limb. An even operand yields a
// single result with limb 0, index 0, last and bad_operand set. All products
// go through one 64x64 multiplier that takes four 32x32 steps. Limb 0 needs
// seven dependent multiplies (seed refinement plus the first high word), limb 1
// needs one more and each later limb needs two; an even operand needs none.
// A two-entry request queue lets the next requests be accepted while a run is
// in progress, and the result register holds one limb while the next is
// computed.
module word_inverse_series_gen (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wisg_in_if.sink     i_in,
    wisg_out_if.source  o_out
);

    wisg_pkg::t_queue_out w_queue;
    logic                 w_pop;

    // Intake: classify the request and hold it until the sequencer is free.
    wisg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_queue (w_queue)
    );

    // Sequencer: Newton refinement, then the limb recurrence.
    wisg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_queue (w_queue),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

>>> rtl/wisg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wisg_checker: port-level assertions
// Checks result encoding and output stability on the top-level ports.
// ----------------------------------------------------------------------------
module wisg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_limb,
    input logic [5:0]  i_out_limb_index,
    input logic        i_out_last,
    input logic        i_out_bad_operand
);

    // An even operand gives one zero limb at index 0 that closes the run.
    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad_operand |->
            i_out_limb == 64'd0 && i_out_limb_index == 6'd0 && i_out_last)
        else $error("bad operand result malformed");

    // The word inverse of an odd operand is itself odd.
    a_limb0_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_bad_operand && i_out_limb_index == 6'd0 |->
            i_out_limb[0])
        else $error("limb 0 is even");

    // A stalled result stays valid with its limb and index unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_limb) && $stable(i_out_limb_index))
        else $error("result changed while stalled");

endmodule

bind word_inverse_series_gen wisg_checker u_wisg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_limb        (o_out.limb),
    .i_out_limb_index  (o_out.limb_index),
    .i_out_last        (o_out.last),
    .i_out_bad_operand (o_out.bad_operand)
);
